>>> hdl/lmc_pkg.sv
package lmc_pkg;

   localparam int CFG_W       = 11;
   localparam int CSR_IDX_W   = 2;
   localparam int COUNT_W     = 20;
   localparam int QUEUE_DEPTH = 4;

   localparam logic [CSR_IDX_W-1:0] CSR_NUM_ROWS = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_NUM_COLS = 2'd1;

   localparam logic [CFG_W-1:0]   CFG_RESET = 11'd3;
   localparam logic [COUNT_W-1:0] COUNT_MAX = 20'hFFFFF;

   // judge: item closes a window whose center is an interior candidate
   // frame_end: last item of the frame
   typedef struct packed {
      logic judge;
      logic frame_end;
   } lmc_flags_type;

   localparam int FLAGS_W = $bits(lmc_flags_type);

endpackage

>>> hdl/lmc_ram.sv
module lmc_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> hdl/lmc_queue.sv
module lmc_queue #(
   parameter int WIDTH = 98,
   parameter int DEPTH = 4
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       push,
   input  logic [WIDTH-1:0]           wr_data,
   input  logic                       pop,
   output logic                       rd_valid,
   output logic [WIDTH-1:0]           rd_data,
   output logic [$clog2(DEPTH+1)-1:0] level
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int LVL_W = $clog2(DEPTH+1);

   logic [WIDTH-1:0] entry_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [LVL_W-1:0] level_ff, level_in;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      level_in  = level_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH-1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH-1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (push && !pop) begin
         level_in = level_ff + LVL_W'(1);
      end else if (pop && !push) begin
         level_in = level_ff - LVL_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         level_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         level_ff  <= level_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= wr_data;
      end
   end

   assign rd_valid = (level_ff != '0);
   assign rd_data  = entry_ff[rd_ptr_ff];
   assign level    = level_ff;

endmodule

>>> hdl/lmc_front.sv
module lmc_front #(
   parameter int MAX_ROWS    = 1024,
   parameter int MAX_COLS    = 1024,
   parameter int VALUE_WIDTH = 32,
   parameter int QDEPTH      = 4
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic signed [VALUE_WIDTH-1:0]     req_pixel_value,
   input  logic                              csr_wr_en,
   input  logic [lmc_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [lmc_pkg::CFG_W-1:0]         csr_wdata,
   input  logic                              restart,
   input  logic [$clog2(QDEPTH+1)-1:0]       q_level,
   output logic                              push,
   output lmc_pkg::lmc_flags_type            push_flags,
   output logic [VALUE_WIDTH-1:0]            push_pixel,
   output logic [VALUE_WIDTH-1:0]            push_mid,
   output logic [VALUE_WIDTH-1:0]            push_up
);

   import lmc_pkg::*;

   localparam int ROW_W  = $clog2(MAX_ROWS);
   localparam int COL_W  = $clog2(MAX_COLS);
   localparam int ROWS_W = $clog2(MAX_ROWS+1);
   localparam int COLS_W = $clog2(MAX_COLS+1);
   localparam int RCMP_W = (CFG_W > ROWS_W) ? CFG_W : ROWS_W;
   localparam int CCMP_W = (CFG_W > COLS_W) ? CFG_W : COLS_W;
   localparam int LVL_W  = $clog2(QDEPTH+1);

   logic [CFG_W-1:0]       rows_cfg_ff;
   logic [CFG_W-1:0]       cols_cfg_ff;
   logic [ROWS_W-1:0]      rows_eff;
   logic [COLS_W-1:0]      cols_eff;
   logic [ROW_W-1:0]       row_ff, row_in;
   logic [COL_W-1:0]       col_ff, col_in;
   logic                   accept;
   logic                   last_col;
   logic                   last_row;
   logic                   s1_valid_ff;
   logic [COL_W-1:0]       s1_col_ff;
   logic [VALUE_WIDTH-1:0] s1_pixel_ff;
   lmc_flags_type          s1_flags_ff;
   lmc_flags_type          flags_in;
   logic [VALUE_WIDTH-1:0] mid_rd;
   logic [VALUE_WIDTH-1:0] up_rd;

   always_comb begin
      if (rows_cfg_ff == '0) begin
         rows_eff = ROWS_W'(1);
      end else if (RCMP_W'(rows_cfg_ff) > RCMP_W'(MAX_ROWS)) begin
         rows_eff = ROWS_W'(MAX_ROWS);
      end else begin
         rows_eff = ROWS_W'(rows_cfg_ff);
      end
      if (cols_cfg_ff == '0) begin
         cols_eff = COLS_W'(1);
      end else if (CCMP_W'(cols_cfg_ff) > CCMP_W'(MAX_COLS)) begin
         cols_eff = COLS_W'(MAX_COLS);
      end else begin
         cols_eff = COLS_W'(cols_cfg_ff);
      end
   end

   // two items in flight ahead of the queue at most: s1 and the one being taken
   assign req_stall = (q_level >= LVL_W'(QDEPTH-1));
   assign accept    = req_valid && !req_stall;

   assign last_col = ((COLS_W'(col_ff) + COLS_W'(1)) == cols_eff);
   assign last_row = ((ROWS_W'(row_ff) + ROWS_W'(1)) == rows_eff);

   always_comb begin
      col_in = col_ff + COL_W'(1);
      row_in = row_ff;
      if (last_col) begin
         col_in = '0;
         row_in = last_row ? '0 : row_ff + ROW_W'(1);
      end
      flags_in.judge     = (col_ff >= COL_W'(2)) && (row_ff >= ROW_W'(2));
      flags_in.frame_end = last_col && last_row;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rows_cfg_ff <= CFG_RESET;
         cols_cfg_ff <= CFG_RESET;
         row_ff      <= '0;
         col_ff      <= '0;
         s1_valid_ff <= 1'b0;
      end else begin
         if (csr_wr_en && csr_index == CSR_NUM_ROWS) begin
            rows_cfg_ff <= csr_wdata;
         end
         if (csr_wr_en && csr_index == CSR_NUM_COLS) begin
            cols_cfg_ff <= csr_wdata;
         end
         if (restart) begin
            row_ff <= '0;
            col_ff <= '0;
         end else if (accept) begin
            row_ff <= row_in;
            col_ff <= col_in;
         end
         s1_valid_ff <= accept;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_col_ff   <= col_ff;
         s1_pixel_ff <= req_pixel_value;
         s1_flags_ff <= flags_in;
      end
   end

   // middle line: row r-1, upper line: row r-2; both shift down one row per column
   lmc_ram #(.WIDTH(VALUE_WIDTH), .DEPTH(MAX_COLS)) u_mid_line (
      .clock   (clock),
      .wr_en   (s1_valid_ff),
      .wr_addr (s1_col_ff),
      .wr_data (s1_pixel_ff),
      .rd_en   (accept),
      .rd_addr (col_ff),
      .rd_data (mid_rd)
   );

   lmc_ram #(.WIDTH(VALUE_WIDTH), .DEPTH(MAX_COLS)) u_up_line (
      .clock   (clock),
      .wr_en   (s1_valid_ff),
      .wr_addr (s1_col_ff),
      .wr_data (mid_rd),
      .rd_en   (accept),
      .rd_addr (col_ff),
      .rd_data (up_rd)
   );

   assign push       = s1_valid_ff;
   assign push_flags = s1_flags_ff;
   assign push_pixel = s1_pixel_ff;
   assign push_mid   = mid_rd;
   assign push_up    = up_rd;

endmodule

>>> hdl/lmc_back.sv
module lmc_back #(
   parameter int VALUE_WIDTH = 32
) (
   input  logic                                          clock,
   input  logic                                          reset,
   input  logic                                          restart,
   input  logic                                          q_valid,
   input  logic [3*VALUE_WIDTH+lmc_pkg::FLAGS_W-1:0]     q_data,
   output logic                                          pop,
   output logic                                          rsp_valid,
   input  logic                                          rsp_stall,
   output logic [lmc_pkg::COUNT_W-1:0]                   rsp_maxima_count
);

   import lmc_pkg::*;

   localparam int ENTRY_W = 3*VALUE_WIDTH + FLAGS_W;

   lmc_flags_type          e_flags;
   logic [VALUE_WIDTH-1:0] e_pixel;
   logic [VALUE_WIDTH-1:0] e_mid;
   logic [VALUE_WIDTH-1:0] e_up;
   logic [VALUE_WIDTH-1:0] mid1_ff;
   logic [VALUE_WIDTH-1:0] mid2_ff;
   logic [VALUE_WIDTH-1:0] up1_ff;
   logic [VALUE_WIDTH-1:0] pix1_ff;
   logic [COUNT_W-1:0]     count_ff;
   logic [COUNT_W-1:0]     count_in;
   logic [COUNT_W-1:0]     rsp_count_ff;
   logic                   rsp_valid_ff;
   logic                   hit;

   assign e_flags = lmc_flags_type'(q_data[ENTRY_W-1 -: FLAGS_W]);
   assign e_pixel = q_data[3*VALUE_WIDTH-1 -: VALUE_WIDTH];
   assign e_mid   = q_data[2*VALUE_WIDTH-1 -: VALUE_WIDTH];
   assign e_up    = q_data[VALUE_WIDTH-1:0];

   // center is mid1: up, down, left and right around it
   assign hit = e_flags.judge
             && ($signed(mid1_ff) > $signed(up1_ff))
             && ($signed(mid1_ff) > $signed(pix1_ff))
             && ($signed(mid1_ff) > $signed(mid2_ff))
             && ($signed(mid1_ff) > $signed(e_mid));

   assign count_in = (hit && count_ff != COUNT_MAX) ? count_ff + COUNT_W'(1) : count_ff;

   assign pop = q_valid && (!e_flags.frame_end || !rsp_valid_ff || !rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (restart) begin
            count_ff <= '0;
         end else if (pop) begin
            count_ff <= e_flags.frame_end ? '0 : count_in;
         end
         if (pop && e_flags.frame_end) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         mid2_ff <= mid1_ff;
         mid1_ff <= e_mid;
         up1_ff  <= e_up;
         pix1_ff <= e_pixel;
      end
      if (pop && e_flags.frame_end) begin
         rsp_count_ff <= count_in;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_maxima_count = rsp_count_ff;

endmodule

>>> hdl/local_maximum_counter_core.sv
// Counts the interior elements of a raster-scanned frame of signed values that are
// strictly greater than their four neighbors (up, down, left, right). Frame size comes
// from csr index 0 (rows) and 1 (columns); a write to either restarts the frame.
// Writes must go in only while the block is idle, which the block does not enforce.
// One item is taken every cycle while req_stall is low; the count of a frame comes
// out of a register as one rsp item after the frame's last item is taken, and a frame
// under 3 rows or 3 columns gives 0. The count saturates at its maximum. req_stall
// rises once the 4-entry queue ahead of the counter holds three items, which happens
// only while rsp_stall holds a finished count back. Two line buffers of MAX_COLS
// entries each feed the window; no clearing pass is needed after reset.
module local_maximum_counter_core #(
   parameter int MAX_COLS    = 1024,
   parameter int MAX_ROWS    = 1024,
   parameter int VALUE_WIDTH = 32
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  logic signed [VALUE_WIDTH-1:0]  req_pixel_value,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic [lmc_pkg::COUNT_W-1:0]    rsp_maxima_count,
   input  logic                           csr_wr_en,
   input  logic [lmc_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [lmc_pkg::CFG_W-1:0]      csr_wdata
);

   import lmc_pkg::*;

   localparam int ENTRY_W = 3*VALUE_WIDTH + FLAGS_W;
   localparam int LVL_W   = $clog2(QUEUE_DEPTH+1);

   logic                   restart;
   logic                   q_push;
   logic                   q_pop;
   logic                   q_valid;
   logic [ENTRY_W-1:0]     q_wdata;
   logic [ENTRY_W-1:0]     q_rdata;
   logic [LVL_W-1:0]       q_level;
   lmc_flags_type          push_flags;
   lmc_flags_type          q_head_flags;
   logic [VALUE_WIDTH-1:0] push_pixel;
   logic [VALUE_WIDTH-1:0] push_mid;
   logic [VALUE_WIDTH-1:0] push_up;

   assign restart = csr_wr_en && (csr_index == CSR_NUM_ROWS || csr_index == CSR_NUM_COLS);

   lmc_front #(
      .MAX_ROWS    (MAX_ROWS),
      .MAX_COLS    (MAX_COLS),
      .VALUE_WIDTH (VALUE_WIDTH),
      .QDEPTH      (QUEUE_DEPTH)
   ) u_front (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_pixel_value (req_pixel_value),
      .csr_wr_en       (csr_wr_en),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata),
      .restart         (restart),
      .q_level         (q_level),
      .push            (q_push),
      .push_flags      (push_flags),
      .push_pixel      (push_pixel),
      .push_mid        (push_mid),
      .push_up         (push_up)
   );

   assign q_wdata = {push_flags, push_pixel, push_mid, push_up};

   lmc_queue #(.WIDTH(ENTRY_W), .DEPTH(QUEUE_DEPTH)) u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (q_push),
      .wr_data  (q_wdata),
      .pop      (q_pop),
      .rd_valid (q_valid),
      .rd_data  (q_rdata),
      .level    (q_level)
   );

   assign q_head_flags = lmc_flags_type'(q_rdata[ENTRY_W-1 -: FLAGS_W]);

   lmc_back #(.VALUE_WIDTH(VALUE_WIDTH)) u_back (
      .clock            (clock),
      .reset            (reset),
      .restart          (restart),
      .q_valid          (q_valid),
      .q_data           (q_rdata),
      .pop              (q_pop),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_maxima_count (rsp_maxima_count)
   );

   a_queue_bound: assert property (@(posedge clock) disable iff (reset)
      q_level <= LVL_W'(QUEUE_DEPTH))
      else $error("queue level above depth");

   a_accept_push: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> q_push)
      else $error("accepted item not pushed to queue");

   a_no_push_full: assert property (@(posedge clock) disable iff (reset)
      (q_level == LVL_W'(QUEUE_DEPTH)) |-> (!q_push || q_pop))
      else $error("push into full queue");

   a_frame_end_rsp: assert property (@(posedge clock) disable iff (reset)
      (q_pop && q_head_flags.frame_end) |=> rsp_valid)
      else $error("frame end popped without result");

endmodule
